// ===== design/gri_pkg.sv =====
// ----------------------------------------------------------------------------
// gri_pkg
// Shared widths, codes and types for the gyro rotation window integrator.
// ----------------------------------------------------------------------------
package gri_pkg;

	localparam int TIME_W  = 32;
	localparam int RATE_W  = 32;
	localparam int GUARD_W = 21;
	localparam int ANGLE_W = 64;
	localparam int DT_W    = TIME_W + 1;
	localparam int PROD_W  = RATE_W + DT_W;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GUARD_TIME   = 2'd2;

	// configuration reset values
	localparam logic [TIME_W-1:0]  WINDOW_START_RST = 32'h0000_0000;
	localparam logic [TIME_W-1:0]  WINDOW_END_RST   = 32'hFFFF_FFFF;
	localparam logic [GUARD_W-1:0] GUARD_TIME_RST   = 21'd10486;

	// result status codes
	localparam logic [1:0] ST_BEFORE     = 2'd0;
	localparam logic [1:0] ST_ANCHOR     = 2'd1;
	localparam logic [1:0] ST_INTEGRATED = 2'd2;
	localparam logic [1:0] ST_AFTER      = 2'd3;

	// accumulator operations
	localparam logic [1:0] OP_HOLD  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_ADD   = 2'd2;

	// per-lane pipeline control from the top level
	typedef struct packed {
		logic       s1_en;
		logic       s2_en;
		logic       acc_en;
		logic [1:0] op;
	} lane_ctrl_t;

endpackage

// ===== design/gri_ctrl.sv =====
// ----------------------------------------------------------------------------
// gri_ctrl
// Configuration registers, window classification and scan state; produces
// the first pipeline stage (status, accumulator op, time delta).
// ----------------------------------------------------------------------------
module gri_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gri_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [31:0]                          cfg_data,
	input  logic                                 accept,
	input  logic                                 s1_en,
	input  logic                                 new_scan,
	input  logic [gri_pkg::TIME_W-1:0]           sample_time,
	output logic                                 valid_s1,
	output logic [1:0]                           status_s1,
	output logic [1:0]                           op_s1,
	output logic                                 avail_s1,
	output logic signed [gri_pkg::DT_W-1:0]      dt_s1
);
	import gri_pkg::*;

	logic [TIME_W-1:0]  window_start_q;
	logic [TIME_W-1:0]  window_end_q;
	logic [GUARD_W-1:0] guard_time_q;

	logic [TIME_W-1:0] last_time_q;
	logic [1:0]        count_q;
	logic              stopped_q;

	logic [TIME_W-1:0] last_eff;
	logic [1:0]        count_eff;
	logic              stopped_eff;
	logic              below;
	logic              above;
	logic [1:0]        status_nxt;
	logic [1:0]        op_nxt;
	logic [TIME_W-1:0] last_nxt;
	logic [1:0]        count_nxt;
	logic              stopped_nxt;
	logic signed [DT_W-1:0] dt_nxt;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q <= WINDOW_START_RST;
			window_end_q   <= WINDOW_END_RST;
			guard_time_q   <= GUARD_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_START: window_start_q <= cfg_data;
				REG_WINDOW_END:   window_end_q   <= cfg_data;
				REG_GUARD_TIME:   guard_time_q   <= cfg_data[GUARD_W-1:0];
				default: ;
			endcase
		end
	end

	// new scan clears the state ahead of this sample
	assign last_eff    = new_scan ? '0 : last_time_q;
	assign count_eff   = new_scan ? 2'd0 : count_q;
	assign stopped_eff = new_scan ? 1'b0 : stopped_q;

	// guarded window bounds, computed without wrap
	assign below = ({1'b0, sample_time} + {{(DT_W-GUARD_W){1'b0}}, guard_time_q})
		< {1'b0, window_start_q};
	assign above = {1'b0, sample_time}
		> ({1'b0, window_end_q} + {{(DT_W-GUARD_W){1'b0}}, guard_time_q});

	assign dt_nxt = signed'({1'b0, sample_time}) - signed'({1'b0, last_eff});

	// classification
	always_comb begin
		status_nxt  = ST_AFTER;
		op_nxt      = new_scan ? OP_CLEAR : OP_HOLD;
		last_nxt    = last_eff;
		count_nxt   = count_eff;
		stopped_nxt = stopped_eff;
		if (stopped_eff) begin
			status_nxt = ST_AFTER;
		end else if (below) begin
			status_nxt = ST_BEFORE;
		end else if (above) begin
			status_nxt  = ST_AFTER;
			stopped_nxt = 1'b1;
		end else if (count_eff == 2'd0) begin
			status_nxt = ST_ANCHOR;
			op_nxt     = OP_CLEAR;
			last_nxt   = sample_time;
			count_nxt  = 2'd1;
		end else begin
			status_nxt = ST_INTEGRATED;
			op_nxt     = OP_ADD;
			last_nxt   = sample_time;
			count_nxt  = 2'd2;
		end
	end

	// scan state, updated on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			count_q     <= 2'd0;
			stopped_q   <= 1'b0;
		end else if (accept) begin
			last_time_q <= last_nxt;
			count_q     <= count_nxt;
			stopped_q   <= stopped_nxt;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_en) begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (s1_en) begin
			status_s1 <= status_nxt;
			op_s1     <= op_nxt;
			avail_s1  <= (count_nxt == 2'd2);
			dt_s1     <= dt_nxt;
		end
	end

endmodule

// ===== design/gri_lane.sv =====
// ----------------------------------------------------------------------------
// gri_lane
// One axis: rate times time delta, then saturating accumulation into the
// rotation register.
// ----------------------------------------------------------------------------
module gri_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gri_pkg::lane_ctrl_t                  ctrl,
	input  logic signed [gri_pkg::RATE_W-1:0]    rate,
	input  logic signed [gri_pkg::DT_W-1:0]      dt_s1,
	output logic signed [gri_pkg::ANGLE_W-1:0]   angle
);
	import gri_pkg::*;

	localparam int SUM_W = PROD_W + 1;

	logic signed [RATE_W-1:0]  rate_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ANGLE_W-1:0] angle_q;
	logic signed [PROD_W-1:0]  rate_ext;
	logic signed [PROD_W-1:0]  dt_ext;
	logic signed [SUM_W-1:0]   sum;
	logic signed [ANGLE_W-1:0] sum_sat;

	// stage 1 rate capture
	always_ff @(posedge clk) begin
		if (ctrl.s1_en) begin
			rate_s1 <= rate;
		end
	end

	// stage 2 product
	assign rate_ext = {{(PROD_W-RATE_W){rate_s1[RATE_W-1]}}, rate_s1};
	assign dt_ext   = {{(PROD_W-DT_W){dt_s1[DT_W-1]}}, dt_s1};

	always_ff @(posedge clk) begin
		if (ctrl.s2_en) begin
			prod_s2 <= rate_ext * dt_ext;
		end
	end

	// saturating add
	assign sum = {{(SUM_W-ANGLE_W){angle_q[ANGLE_W-1]}}, angle_q}
		+ {prod_s2[PROD_W-1], prod_s2};

	always_comb begin
		if (sum[SUM_W-1:ANGLE_W-1] == '0 || sum[SUM_W-1:ANGLE_W-1] == '1) begin
			sum_sat = sum[ANGLE_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sum_sat = {1'b1, {(ANGLE_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(ANGLE_W-1){1'b1}}};
		end
	end

	// accumulator, doubles as the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
		end else if (ctrl.acc_en) begin
			case (ctrl.op)
				OP_CLEAR: angle_q <= '0;
				OP_ADD:   angle_q <= sum_sat;
				default:  angle_q <= angle_q;
			endcase
		end
	end

	assign angle = angle_q;

endmodule

// ===== design/gyro_rotation_window_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// gyro_rotation_window_integrator_unit
// Windowed rectangular integration of three gyro rates into rotations.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   input    | in_valid / in_stall    | new_scan, sample_time, rate_x/y/z
//   output   | out_valid / out_stall  | status, angle_x/y/z, available
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One sample per clock while the output is not stalled, through three register stages
// (classify, multiply, accumulate); results leave the accumulate stage in sample order.
// Scan state is updated in the classify stage, the per-axis accumulators
// close a feedback loop through their own register.
// Reset clears the scan state and rotations and loads the register defaults.
// A stalled output holds the result; upstream stages keep filling bubbles and
// the input stalls only when every stage is occupied.
// ----------------------------------------------------------------------------
module gyro_rotation_window_integrator_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [gri_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [31:0]                           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  new_scan,
	input  logic [gri_pkg::TIME_W-1:0]            sample_time,
	input  logic signed [gri_pkg::RATE_W-1:0]     rate_x,
	input  logic signed [gri_pkg::RATE_W-1:0]     rate_y,
	input  logic signed [gri_pkg::RATE_W-1:0]     rate_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [1:0]                            status,
	output logic signed [gri_pkg::ANGLE_W-1:0]    angle_x,
	output logic signed [gri_pkg::ANGLE_W-1:0]    angle_y,
	output logic signed [gri_pkg::ANGLE_W-1:0]    angle_z,
	output logic                                  available
);
	import gri_pkg::*;

	logic              valid_s1;
	logic [1:0]        status_s1;
	logic [1:0]        op_s1;
	logic              avail_s1;
	logic signed [DT_W-1:0] dt_s1;

	logic              valid_s2;
	logic [1:0]        status_s2;
	logic [1:0]        op_s2;
	logic              avail_s2;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic              available_q;

	logic              out_adv;
	logic              s2_adv;
	logic              s1_adv;
	logic              accept;
	lane_ctrl_t        lane_ctrl;

	// stage advance chain
	assign out_adv  = !out_valid_q || !out_stall;
	assign s2_adv   = !valid_s2 || out_adv;
	assign s1_adv   = !valid_s1 || s2_adv;
	assign in_stall = !s1_adv;
	assign accept   = in_valid && s1_adv;
	assign cfg_ready = 1'b1;

	gri_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.s1_en       (s1_adv),
		.new_scan    (new_scan),
		.sample_time (sample_time),
		.valid_s1    (valid_s1),
		.status_s1   (status_s1),
		.op_s1       (op_s1),
		.avail_s1    (avail_s1),
		.dt_s1       (dt_s1)
	);

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			status_s2 <= status_s1;
			op_s2     <= op_s1;
			avail_s2  <= avail_s1;
		end
	end

	assign lane_ctrl.s1_en  = s1_adv;
	assign lane_ctrl.s2_en  = s2_adv;
	assign lane_ctrl.acc_en = out_adv && valid_s2;
	assign lane_ctrl.op     = op_s2;

	// one lane per axis
	gri_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.rate   (rate_x),
		.dt_s1  (dt_s1),
		.angle  (angle_x)
	);

	gri_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.rate   (rate_y),
		.dt_s1  (dt_s1),
		.angle  (angle_y)
	);

	gri_lane u_lane_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.rate   (rate_z),
		.dt_s1  (dt_s1),
		.angle  (angle_z)
	);

	// output register merging lane results with status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s2) begin
			status_q    <= status_s2;
			available_q <= avail_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign available = available_q;

endmodule

// ===== test/rotation_checker.sv =====
// ----------------------------------------------------------------------------
// rotation_checker
// Watches the sample, result and register channels of the gyro rotation
// window integrator. Every sample transfer runs through a local integrator
// (window test, anchor, rectangular step with saturation) and queues the
// expected result; every result transfer is compared with the oldest one.
// ----------------------------------------------------------------------------
module rotation_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [gri_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [31:0]                           cfg_data,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic                                  new_scan,
	input  logic [gri_pkg::TIME_W-1:0]            sample_time,
	input  logic signed [gri_pkg::RATE_W-1:0]     rate_x,
	input  logic signed [gri_pkg::RATE_W-1:0]     rate_y,
	input  logic signed [gri_pkg::RATE_W-1:0]     rate_z,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic [1:0]                            status,
	input  logic signed [gri_pkg::ANGLE_W-1:0]    angle_x,
	input  logic signed [gri_pkg::ANGLE_W-1:0]    angle_y,
	input  logic signed [gri_pkg::ANGLE_W-1:0]    angle_z,
	input  logic                                  available,
	output int                                    mismatches,
	output int                                    pending,
	output int                                    checked
);
	import gri_pkg::*;

	localparam int REPORT_LIMIT = 10;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
	localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

	typedef struct packed {
		logic [1:0]                status;
		logic signed [ANGLE_W-1:0] angle_x;
		logic signed [ANGLE_W-1:0] angle_y;
		logic signed [ANGLE_W-1:0] angle_z;
		logic                      available;
	} rotation_t;

	// local copy of the registers and the scan state
	logic [TIME_W-1:0]         win_start;
	logic [TIME_W-1:0]         win_end;
	logic [GUARD_W-1:0]        guard;
	logic [TIME_W-1:0]         prev_time;
	logic signed [ANGLE_W-1:0] rot [3];
	logic [1:0]                in_window_cnt;
	logic                      halted;

	rotation_t expected_rotations [$];
	rotation_t want_rot;
	rotation_t got_rot;
	rotation_t next_rot;

	function automatic logic signed [ANGLE_W-1:0] sat_add(
		input logic signed [ANGLE_W-1:0] a,
		input logic signed [ANGLE_W-1:0] b
	);
		logic signed [ANGLE_W:0] wide;
		wide = {a[ANGLE_W-1], a} + {b[ANGLE_W-1], b};
		// top two bits differ only when the true sum left the 64-bit range
		if (wide[ANGLE_W] != wide[ANGLE_W-1])
			return wide[ANGLE_W] ? ANGLE_MIN : ANGLE_MAX;
		return wide[ANGLE_W-1:0];
	endfunction

	task automatic clear_scan();
		prev_time = '0;
		for (int i = 0; i < 3; i++)
			rot[i] = '0;
		in_window_cnt = '0;
		halted = 1'b0;
	endtask

	// one sample through the window integrator
	task automatic integrate_sample(
		input  logic                      scan_start,
		input  logic [TIME_W-1:0]         t,
		input  logic signed [RATE_W-1:0]  rx,
		input  logic signed [RATE_W-1:0]  ry,
		input  logic signed [RATE_W-1:0]  rz,
		output rotation_t                 r
	);
		logic [TIME_W:0]            early_sum;
		logic [TIME_W:0]            late_edge;
		logic signed [DT_W-1:0]     dt;
		logic signed [PROD_W-1:0]   prod;
		logic signed [RATE_W-1:0]   rate [3];
		logic [1:0]                 st;
		if (scan_start)
			clear_scan();
		rate[0] = rx;
		rate[1] = ry;
		rate[2] = rz;
		// bounds are one bit wider so nothing wraps
		early_sum = {1'b0, t} + {{(TIME_W+1-GUARD_W){1'b0}}, guard};
		late_edge = {1'b0, win_end} + {{(TIME_W+1-GUARD_W){1'b0}}, guard};
		if (halted) begin
			st = ST_AFTER;
		end else if (early_sum < {1'b0, win_start}) begin
			st = ST_BEFORE;
		end else if ({1'b0, t} > late_edge) begin
			halted = 1'b1;
			st = ST_AFTER;
		end else if (in_window_cnt == 2'd0) begin
			for (int i = 0; i < 3; i++)
				rot[i] = '0;
			prev_time = t;
			in_window_cnt = 2'd1;
			st = ST_ANCHOR;
		end else begin
			// signed time step, so going backwards flips the increment
			dt = $signed({1'b0, t}) - $signed({1'b0, prev_time});
			for (int i = 0; i < 3; i++) begin
				prod = PROD_W'(rate[i]) * PROD_W'(dt);
				rot[i] = sat_add(rot[i], prod[ANGLE_W-1:0]);
			end
			prev_time = t;
			in_window_cnt = 2'd2;
			st = ST_INTEGRATED;
		end
		r.status    = st;
		r.angle_x   = rot[0];
		r.angle_y   = rot[1];
		r.angle_z   = rot[2];
		r.available = (in_window_cnt >= 2'd2);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start = WINDOW_START_RST;
			win_end   = WINDOW_END_RST;
			guard     = GUARD_TIME_RST;
			clear_scan();
			expected_rotations.delete();
			mismatches = 0;
			checked    = 0;
			pending    = 0;
		end else begin
			// result transfer against the oldest prediction
			if (out_valid && !out_stall) begin
				got_rot.status    = status;
				got_rot.angle_x   = angle_x;
				got_rot.angle_y   = angle_y;
				got_rot.angle_z   = angle_z;
				got_rot.available = available;
				if (expected_rotations.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("unexpected result: status %0d x %0d y %0d z %0d available %0d",
							got_rot.status, got_rot.angle_x, got_rot.angle_y,
							got_rot.angle_z, got_rot.available);
					mismatches++;
				end else begin
					want_rot = expected_rotations.pop_front();
					checked++;
					if (got_rot.status !== want_rot.status ||
						got_rot.angle_x !== want_rot.angle_x ||
						got_rot.angle_y !== want_rot.angle_y ||
						got_rot.angle_z !== want_rot.angle_z ||
						got_rot.available !== want_rot.available) begin
						if (mismatches < REPORT_LIMIT) begin
							$display("rotation mismatch on result %0d", checked);
							$display("  expected status %0d x %0d y %0d z %0d available %0d",
								want_rot.status, want_rot.angle_x, want_rot.angle_y,
								want_rot.angle_z, want_rot.available);
							$display("  actual   status %0d x %0d y %0d z %0d available %0d",
								got_rot.status, got_rot.angle_x, got_rot.angle_y,
								got_rot.angle_z, got_rot.available);
						end
						mismatches++;
					end
				end
			end

			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW_START: win_start = cfg_data;
					REG_WINDOW_END:   win_end = cfg_data;
					REG_GUARD_TIME:   guard = cfg_data[GUARD_W-1:0];
					default: ;
				endcase
			end

			// sample transfer
			if (in_valid && !in_stall) begin
				integrate_sample(new_scan, sample_time, rate_x, rate_y, rate_z, next_rot);
				expected_rotations.insert(expected_rotations.size(), next_rot);
			end

			pending = expected_rotations.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives gyro samples and window settings into the integrator and lets the
// rotation checker score every result. A directed opening covers rate and
// time extremes, backward time, saturation and the window edges; then random
// window settings are swept by well-formed scans with some noise, under
// random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import gri_pkg::*;

	localparam int    WATCHDOG_LIMIT = 4000;
	localparam int    HOLD_CYCLES    = 300;
	localparam int    SETTLE_CYCLES  = 8;
	localparam int    TARGET_SAMPLES = 1050;
	localparam longint TIME_TOP      = 64'h0000_0000_FFFF_FFFF;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [31:0]               cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic                      new_scan;
	logic [TIME_W-1:0]         sample_time;
	logic signed [RATE_W-1:0]  rate_x;
	logic signed [RATE_W-1:0]  rate_y;
	logic signed [RATE_W-1:0]  rate_z;
	logic                      out_valid;
	logic                      out_stall;
	logic [1:0]                status;
	logic signed [ANGLE_W-1:0] angle_x;
	logic signed [ANGLE_W-1:0] angle_y;
	logic signed [ANGLE_W-1:0] angle_z;
	logic                      available;

	int mismatches;
	int pending;
	int checked;
	int samples_sent;
	int reg_writes;
	int settings_used;
	int quiet_cycles;
	bit idle_en;
	bit hold_req;

	gyro_rotation_window_integrator_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.new_scan   (new_scan),
		.sample_time(sample_time),
		.rate_x     (rate_x),
		.rate_y     (rate_y),
		.rate_z     (rate_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.angle_x    (angle_x),
		.angle_y    (angle_y),
		.angle_z    (angle_z),
		.available  (available)
	);

	rotation_checker u_rotation_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.new_scan   (new_scan),
		.sample_time(sample_time),
		.rate_x     (rate_x),
		.rate_y     (rate_y),
		.rate_z     (rate_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.angle_x    (angle_x),
		.angle_y    (angle_y),
		.angle_z    (angle_z),
		.available  (available),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side: random stalls, or a long hold-off when asked
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = idle_en && ($urandom_range(0, 99) < 16);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	function automatic logic signed [RATE_W-1:0] rand_rate();
		case ($urandom_range(0, 9))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2, 3:    return $signed($urandom_range(0, 2000)) - 1000;
			default: return $urandom;
		endcase
	endfunction

	// one sample transfer, with random gaps ahead of it
	task automatic push_sample(
		input logic                     scan_start,
		input logic [TIME_W-1:0]        t,
		input logic signed [RATE_W-1:0] rx,
		input logic signed [RATE_W-1:0] ry,
		input logic signed [RATE_W-1:0] rz
	);
		while (idle_en && $urandom_range(0, 99) < 16) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		new_scan    = scan_start;
		sample_time = t;
		rate_x      = rx;
		rate_y      = ry;
		rate_z      = rz;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		samples_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		reg_writes++;
	endtask

	// wait until every predicted result has come out
	task automatic settle();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_window(
		input logic [TIME_W-1:0]  ws,
		input logic [TIME_W-1:0]  we,
		input logic [GUARD_W-1:0] g
	);
		settle();
		write_reg(REG_WINDOW_START, ws);
		write_reg(REG_WINDOW_END, we);
		write_reg(REG_GUARD_TIME, {11'd0, g});
		settings_used++;
	endtask

	// one scan from before the window to past it, with some noise
	task automatic sweep_window(
		input logic [TIME_W-1:0]  ws,
		input logic [TIME_W-1:0]  we,
		input logic [GUARD_W-1:0] g
	);
		longint span;
		longint step;
		longint t;
		longint hi;
		span = longint'(we) - longint'(ws) + 2 * longint'(g);
		step = (span > 0) ? span / 12 + 1 : 1 + longint'($urandom_range(0, 64));
		t = longint'(ws) - longint'(g) - 3 * step;
		if (t < 0)
			t = 0;
		hi = longint'(we) + longint'(g) + 3 * step;
		push_sample(1'b1, t[31:0], rand_rate(), rand_rate(), rand_rate());
		for (int n = 0; n < 40 && t < hi; n++) begin
			case ($urandom_range(0, 39))
				0:       t = t - longint'($urandom_range(0, 32'(step)));
				1:       t = longint'($urandom);
				default: t = t + longint'($urandom_range(0, 32'(2 * step)));
			endcase
			if (t < 0)
				t = 0;
			if (t > TIME_TOP)
				t = TIME_TOP;
			push_sample($urandom_range(0, 49) == 0, t[31:0], rand_rate(), rand_rate(),
				rand_rate());
		end
	endtask

	initial begin
		logic [TIME_W-1:0]  ws;
		logic [TIME_W-1:0]  we;
		logic [GUARD_W-1:0] g;
		int                 width;
		int                 phase;

		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		new_scan     = 1'b0;
		sample_time  = '0;
		rate_x       = '0;
		rate_y       = '0;
		rate_z       = '0;
		idle_en      = 1'b1;
		hold_req     = 1'b0;
		samples_sent = 0;
		reg_writes   = 0;
		settings_used = 1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// default window: start below guard, rate extremes, backward time, saturation
		push_sample(1'b1, 32'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
		push_sample(1'b0, 32'd100, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1);
		push_sample(1'b0, 32'd50, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1);
		push_sample(1'b0, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		push_sample(1'b0, 32'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		push_sample(1'b0, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		push_sample(1'b0, 32'hFFFF_FFFF, 32'sd0, 32'sd0, 32'sd0);
		push_sample(1'b1, 32'd5, 32'sd1, -32'sd1, 32'sd0);

		// tight window without guard: before, anchor, steps, stop, ignored, restart
		set_window(32'h0001_0000, 32'h0002_0000, 21'd0);
		push_sample(1'b1, 32'h0000_FFFF, 32'sd7, 32'sd8, 32'sd9);
		push_sample(1'b0, 32'h0001_0000, 32'sd3, -32'sd4, 32'sd5);
		push_sample(1'b0, 32'h0001_8000, 32'sd1000, -32'sd2000, 32'sh7FFF_FFFF);
		push_sample(1'b0, 32'h0002_0000, -32'sd1000, 32'sd2000, 32'sh8000_0000);
		push_sample(1'b0, 32'h0002_0001, 32'sd11, 32'sd12, 32'sd13);
		push_sample(1'b0, 32'h0001_8000, 32'sd11, 32'sd12, 32'sd13);
		push_sample(1'b1, 32'h0001_8000, 32'sd21, 32'sd22, 32'sd23);
		push_sample(1'b1, 32'h0002_0001, 32'sd31, 32'sd32, 32'sd33);

		// inverted window at the extremes with the widest guard
		set_window(32'hFFFF_FFFF, 32'd0, 21'h1F_FFFF);
		push_sample(1'b1, 32'd0, 32'sd1, 32'sd2, 32'sd3);
		push_sample(1'b0, 32'hFFE0_0001, 32'sd4, 32'sd5, 32'sd6);
		push_sample(1'b1, 32'h001F_FFFF, 32'sd7, 32'sd8, 32'sd9);

		// random windows swept by scans
		phase = 0;
		while (samples_sent < TARGET_SAMPLES) begin
			case (phase)
				0: begin
					ws = 32'd0;
					we = 32'hFFFF_FFFF;
					g  = 21'h1F_FFFF;
				end
				1: begin
					ws = 32'hFFFF_FFFF;
					we = 32'hFFFF_FFFF;
					g  = 21'd0;
				end
				2: begin
					ws = 32'd0;
					we = 32'd0;
					g  = 21'd1048576;
				end
				default: begin
					ws = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 200000) : $urandom;
					width = $urandom_range(0, 60000);
					we = (longint'(ws) + width > TIME_TOP) ? 32'hFFFF_FFFF : ws + width;
					if ($urandom_range(0, 7) == 0)
						we = ws - $urandom_range(0, 1000);
					case ($urandom_range(0, 3))
						0:       g = 21'd0;
						1:       g = 21'd1048576;
						2:       g = 21'($urandom_range(0, 1048576));
						default: g = 21'($urandom_range(0, 4000));
					endcase
				end
			endcase
			set_window(ws, we, g);
			// a stretch with no idling, and one long output hold-off inside it
			idle_en = !(phase >= 4 && phase < 8);
			if (phase == 5)
				hold_req = 1'b1;
			repeat ($urandom_range(2, 5)) sweep_window(ws, we, g);
			phase++;
		end

		settle();
		$display("covered %0d samples over %0d window settings, %0d register writes",
			samples_sent, settings_used, reg_writes);
		$display("%0d results compared with the predicted rotations", checked);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== gyro_rotation_window_integrator_unit.f =====
design/gri_pkg.sv
design/gri_ctrl.sv
design/gri_lane.sv
design/gyro_rotation_window_integrator_unit.sv
test/rotation_checker.sv
test/testbench.sv
